// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the encoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define RVENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define RVENC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rvenc_pkg.sv -----
// ---------------------------------------------------------------------------
// rvenc_pkg
// Types, opcode constants and the mnemonic table of the RV32IM encoder.
// ---------------------------------------------------------------------------
package rvenc_pkg;

  typedef struct packed {
    logic [5:0]         action;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] imm_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        error;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    KIND_R, KIND_I, KIND_SH, KIND_MV, KIND_JR, KIND_EC, KIND_S,
    KIND_B, KIND_BZ, KIND_U, KIND_J, KIND_JZ, KIND_LI
  } kind_t;

  typedef enum logic [5:0] {
    ACT_JAL, ACT_J, ACT_ADD, ACT_MUL, ACT_SUB, ACT_SLL, ACT_MULH, ACT_SLT,
    ACT_SLTU, ACT_XOR, ACT_DIV, ACT_SRL, ACT_SRA, ACT_OR, ACT_REM, ACT_AND,
    ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU, ACT_ADDI, ACT_MV, ACT_SLLI,
    ACT_SLTI, ACT_SLTIU, ACT_XORI, ACT_SRLI, ACT_SRAI, ACT_ORI, ACT_ANDI,
    ACT_JALR, ACT_JR, ACT_ECALL, ACT_SB, ACT_SH, ACT_SW, ACT_BEQ, ACT_BEQZ,
    ACT_BNE, ACT_BNEZ, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU, ACT_AUIPC,
    ACT_LUI, ACT_LI
  } action_t;

  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [31:0] ECALL_WORD = {25'd0, OPC_SYSTEM};

  localparam logic signed [31:0] IMM12_MIN  = -32'sd2048;
  localparam logic signed [31:0] IMM12_MAX  = 32'sd2047;
  localparam logic signed [31:0] SHAMT_MAX  = 32'sd31;
  localparam logic signed [31:0] BOFF_MIN   = -32'sd4096;
  localparam logic signed [31:0] BOFF_MAX   = 32'sd4094;
  localparam logic signed [31:0] UIMM_MAX   = 32'sd1048575;
  localparam logic signed [31:0] JOFF_MIN   = -32'sd1048576;
  localparam logic signed [31:0] JOFF_MAX   = 32'sd1048575;
  localparam logic signed [31:0] LI_BAD     = 32'sh8000_0000;

  typedef struct packed {
    logic       known;
    kind_t      kind;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
  } op_row_t;

  typedef struct packed {
    logic        err;
    logic        li_two;
    kind_t       kind;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } q_entry_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  function automatic op_row_t mk_row(input kind_t k, input logic [6:0] o,
                                     input logic [2:0] f, input logic [6:0] h);
    op_row_t r;
    r.known = 1'b1;
    r.kind  = k;
    r.opc   = o;
    r.f3    = f;
    r.f7    = h;
    return r;
  endfunction

  function automatic op_row_t lookup_op(input logic [5:0] act);
    op_row_t r;
    unique case (action_t'(act))
      ACT_JAL:   r = mk_row(KIND_J,  OPC_JAL,    3'd0, F7_BASE);
      ACT_J:     r = mk_row(KIND_JZ, OPC_JAL,    3'd0, F7_BASE);
      ACT_ADD:   r = mk_row(KIND_R,  OPC_OP,     3'd0, F7_BASE);
      ACT_MUL:   r = mk_row(KIND_R,  OPC_OP,     3'd0, F7_MULDIV);
      ACT_SUB:   r = mk_row(KIND_R,  OPC_OP,     3'd0, F7_ALT);
      ACT_SLL:   r = mk_row(KIND_R,  OPC_OP,     3'd1, F7_BASE);
      ACT_MULH:  r = mk_row(KIND_R,  OPC_OP,     3'd1, F7_MULDIV);
      ACT_SLT:   r = mk_row(KIND_R,  OPC_OP,     3'd2, F7_BASE);
      ACT_SLTU:  r = mk_row(KIND_R,  OPC_OP,     3'd3, F7_BASE);
      ACT_XOR:   r = mk_row(KIND_R,  OPC_OP,     3'd4, F7_BASE);
      ACT_DIV:   r = mk_row(KIND_R,  OPC_OP,     3'd4, F7_MULDIV);
      ACT_SRL:   r = mk_row(KIND_R,  OPC_OP,     3'd5, F7_BASE);
      ACT_SRA:   r = mk_row(KIND_R,  OPC_OP,     3'd5, F7_ALT);
      ACT_OR:    r = mk_row(KIND_R,  OPC_OP,     3'd6, F7_BASE);
      ACT_REM:   r = mk_row(KIND_R,  OPC_OP,     3'd6, F7_MULDIV);
      ACT_AND:   r = mk_row(KIND_R,  OPC_OP,     3'd7, F7_BASE);
      ACT_LB:    r = mk_row(KIND_I,  OPC_LOAD,   3'd0, F7_BASE);
      ACT_LH:    r = mk_row(KIND_I,  OPC_LOAD,   3'd1, F7_BASE);
      ACT_LW:    r = mk_row(KIND_I,  OPC_LOAD,   3'd2, F7_BASE);
      ACT_LBU:   r = mk_row(KIND_I,  OPC_LOAD,   3'd4, F7_BASE);
      ACT_LHU:   r = mk_row(KIND_I,  OPC_LOAD,   3'd5, F7_BASE);
      ACT_ADDI:  r = mk_row(KIND_I,  OPC_OPIMM,  3'd0, F7_BASE);
      ACT_MV:    r = mk_row(KIND_MV, OPC_OPIMM,  3'd0, F7_BASE);
      ACT_SLLI:  r = mk_row(KIND_SH, OPC_OPIMM,  3'd1, F7_BASE);
      ACT_SLTI:  r = mk_row(KIND_I,  OPC_OPIMM,  3'd2, F7_BASE);
      ACT_SLTIU: r = mk_row(KIND_I,  OPC_OPIMM,  3'd3, F7_BASE);
      ACT_XORI:  r = mk_row(KIND_I,  OPC_OPIMM,  3'd4, F7_BASE);
      ACT_SRLI:  r = mk_row(KIND_SH, OPC_OPIMM,  3'd5, F7_BASE);
      ACT_SRAI:  r = mk_row(KIND_SH, OPC_OPIMM,  3'd5, F7_ALT);
      ACT_ORI:   r = mk_row(KIND_I,  OPC_OPIMM,  3'd6, F7_BASE);
      ACT_ANDI:  r = mk_row(KIND_I,  OPC_OPIMM,  3'd7, F7_BASE);
      ACT_JALR:  r = mk_row(KIND_I,  OPC_JALR,   3'd0, F7_BASE);
      ACT_JR:    r = mk_row(KIND_JR, OPC_JALR,   3'd0, F7_BASE);
      ACT_ECALL: r = mk_row(KIND_EC, OPC_SYSTEM, 3'd0, F7_BASE);
      ACT_SB:    r = mk_row(KIND_S,  OPC_STORE,  3'd0, F7_BASE);
      ACT_SH:    r = mk_row(KIND_S,  OPC_STORE,  3'd1, F7_BASE);
      ACT_SW:    r = mk_row(KIND_S,  OPC_STORE,  3'd2, F7_BASE);
      ACT_BEQ:   r = mk_row(KIND_B,  OPC_BRANCH, 3'd0, F7_BASE);
      ACT_BEQZ:  r = mk_row(KIND_BZ, OPC_BRANCH, 3'd0, F7_BASE);
      ACT_BNE:   r = mk_row(KIND_B,  OPC_BRANCH, 3'd1, F7_BASE);
      ACT_BNEZ:  r = mk_row(KIND_BZ, OPC_BRANCH, 3'd1, F7_BASE);
      ACT_BLT:   r = mk_row(KIND_B,  OPC_BRANCH, 3'd4, F7_BASE);
      ACT_BGE:   r = mk_row(KIND_B,  OPC_BRANCH, 3'd5, F7_BASE);
      ACT_BLTU:  r = mk_row(KIND_B,  OPC_BRANCH, 3'd6, F7_BASE);
      ACT_BGEU:  r = mk_row(KIND_B,  OPC_BRANCH, 3'd7, F7_BASE);
      ACT_AUIPC: r = mk_row(KIND_U,  OPC_AUIPC,  3'd0, F7_BASE);
      ACT_LUI:   r = mk_row(KIND_U,  OPC_LUI,    3'd0, F7_BASE);
      ACT_LI:    r = mk_row(KIND_LI, OPC_LUI,    3'd0, F7_BASE);
      default: begin
        r = mk_row(KIND_R, OPC_OP, 3'd0, F7_BASE);
        r.known = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- sv/rv32im_instruction_encoder_top.sv -----
// ---------------------------------------------------------------------------
// rv32im_instruction_encoder_top
// RV32IM instruction encoder: mnemonic code and operands in, machine words out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one mnemonic code,
//   rd, rs1, rs2 and a signed immediate; a transfer happens on a clk edge
//   with in_valid high and in_stall low.
//   Output channel out_valid / out_stall / out_data returns the machine
//   word, an error flag and a last flag per result.
//   Most items give one result; li with an immediate outside 12 bits gives
//   a lui word (last low) followed by an addi word (last high). An unknown
//   code or an out-of-range immediate gives one result: word 0, error high.
//   After the input register loads on the transfer edge, the item goes
//   through the queue write, then the output register, before out_valid rises.
//   Throughput is one item per cycle while out_stall is low; a two-word
//   li holds the word builder for both words and stalls a continuous stream.
//   While out_stall is high the output register holds; the two-entry queue
//   and input register fill, then in_stall rises.
//   rst_n is synchronous and active low; it empties every stage.
// ---------------------------------------------------------------------------
module rv32im_instruction_encoder_top import rvenc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_wdata, q_rdata;

  rvenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rvenc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  rvenc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/rvenc_front.sv -----
// ---------------------------------------------------------------------------
// rvenc_front
// Input register, mnemonic lookup and immediate range check; pushes one
// classified entry per item into the queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rvenc_front import rvenc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_wdata
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;
  op_row_t  row;
  logic     range_ok;
  logic     small_imm;
  logic signed [31:0] s;

  assign in_stall = valid_r && q_full;
  assign load     = !in_stall;
  assign q_push   = valid_r && !q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_data;
    end
  end

  assign row       = lookup_op(item_r.action);
  assign s         = item_r.imm_value;
  assign small_imm = (s >= IMM12_MIN) && (s <= IMM12_MAX);

  always_comb begin
    case (row.kind)
      KIND_I, KIND_S:   range_ok = small_imm;
      KIND_SH:          range_ok = (s >= 32'sd0) && (s <= SHAMT_MAX);
      KIND_B, KIND_BZ:  range_ok = (s >= BOFF_MIN) && (s <= BOFF_MAX);
      KIND_U:           range_ok = (s >= 32'sd0) && (s <= UIMM_MAX);
      KIND_J, KIND_JZ:  range_ok = (s >= JOFF_MIN) && (s <= JOFF_MAX);
      KIND_LI:          range_ok = (s != LI_BAD);
      default:          range_ok = 1'b1;
    endcase
  end

  always_comb begin
    q_wdata.err    = !row.known || !range_ok;
    q_wdata.li_two = !small_imm;
    q_wdata.kind   = row.kind;
    q_wdata.opc    = row.opc;
    q_wdata.f3     = row.f3;
    q_wdata.f7     = row.f7;
    q_wdata.rd     = item_r.dest_reg;
    q_wdata.rs1    = item_r.src1_reg;
    q_wdata.rs2    = item_r.src2_reg;
    q_wdata.imm    = item_r.imm_value;
  end

  // a held item must be pushed before a new one can land in the register
  `RVENC_ASSERT(a_front_hold, valid_r && q_full |=> valid_r && $stable(item_r), "front item lost while queue full")

endmodule

// ----- sv/rvenc_queue.sv -----
// ---------------------------------------------------------------------------
// rvenc_queue
// Small FIFO of classified entries between the front and back halves.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rvenc_queue import rvenc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t rdata
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `RVENC_ASSERT(a_q_no_overflow, !(push && full), "push into full queue")
  `RVENC_ASSERT(a_q_count, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "queue count slip")

endmodule

// ----- sv/rvenc_back.sv -----
// ---------------------------------------------------------------------------
// rvenc_back
// Builds machine words from queue entries into the output register; a
// two-word li holds its queue entry until its second word is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rvenc_back import rvenc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_entry_t  q_rdata,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      phase_r, phase_nxt;
  logic      adv, take, two;
  logic [4:0]  rs2_f, rd_f;
  logic [19:0] up;
  logic [31:0] imm;
  logic [31:0] word;

  assign adv   = !out_valid_r || !out_stall;
  assign take  = adv && !q_empty;
  assign two   = !q_rdata.err && (q_rdata.kind == KIND_LI) && q_rdata.li_two;
  assign q_pop = take && (!two || phase_r);

  assign imm   = q_rdata.imm;
  // lui part rounds up when the addi part will be negative
  assign up    = imm[31:12] + {19'd0, imm[11]};
  assign rs2_f = (q_rdata.kind == KIND_BZ) ? 5'd0 : q_rdata.rs2;
  assign rd_f  = (q_rdata.kind == KIND_JZ) ? 5'd0 : q_rdata.rd;

  always_comb begin
    case (q_rdata.kind)
      KIND_R:  word = {q_rdata.f7, q_rdata.rs2, q_rdata.rs1, q_rdata.f3,
                       q_rdata.rd, q_rdata.opc};
      KIND_I:  word = {imm[11:0], q_rdata.rs1, q_rdata.f3, q_rdata.rd, q_rdata.opc};
      KIND_SH: word = {q_rdata.f7, imm[4:0], q_rdata.rs1, q_rdata.f3,
                       q_rdata.rd, q_rdata.opc};
      KIND_MV: word = {12'd0, q_rdata.rs1, 3'd0, q_rdata.rd, q_rdata.opc};
      KIND_JR: word = {12'd0, q_rdata.rs1, 3'd0, 5'd0, q_rdata.opc};
      KIND_EC: word = ECALL_WORD;
      KIND_S:  word = {imm[11:5], q_rdata.rs2, q_rdata.rs1, q_rdata.f3,
                       imm[4:0], q_rdata.opc};
      KIND_B, KIND_BZ:
               word = {imm[12], imm[10:5], rs2_f, q_rdata.rs1, q_rdata.f3,
                       imm[4:1], imm[11], q_rdata.opc};
      KIND_U:  word = {imm[19:0], q_rdata.rd, q_rdata.opc};
      KIND_J, KIND_JZ:
               word = {imm[20], imm[10:1], imm[11], imm[19:12], rd_f, q_rdata.opc};
      KIND_LI: begin
        if (!two) begin
          word = {imm[11:0], 5'd0, 3'd0, q_rdata.rd, OPC_OPIMM};
        end else if (!phase_r) begin
          word = {up, q_rdata.rd, OPC_LUI};
        end else begin
          word = {imm[11:0], q_rdata.rd, 3'd0, q_rdata.rd, OPC_OPIMM};
        end
      end
      default: word = '0;
    endcase
  end

  always_comb begin
    out_data_nxt.word  = q_rdata.err ? 32'd0 : word;
    out_data_nxt.error = q_rdata.err;
    out_data_nxt.last  = !(two && !phase_r);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      phase_nxt     = two && !phase_r;
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RVENC_ASSERT(a_err_word, out_valid_r && out_data_r.error |-> out_data_r.word == 32'd0 && out_data_r.last, "error result malformed")
  `RVENC_ASSERT(a_li_head, phase_r |-> !q_empty && !out_data_r.last, "li second word lost its entry")

endmodule

// ----- verif/rv32im_instruction_encoder_top_test.sv -----
// ---------------------------------------------------------------------------
// rv32im_instruction_encoder_top_test
// Self-checking bench for the RV32IM encoder: directed field extremes and
// pseudo-ops, a long output hold-off, then a random instruction stream with
// bursty input and a patterned output stall. Every output transfer is
// checked against machine words predicted at input transfer time.
// ---------------------------------------------------------------------------
module rv32im_instruction_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rvenc_pkg::*;

  localparam logic [5:0] FIRST_UNKNOWN_ACT = 6'd48;
  localparam logic [5:0] LAST_ACT_CODE     = 6'd63;
  localparam int         RESET_CYCLES      = 12;
  localparam int         HOLD_OFF_CYCLES   = 300;
  localparam int         WATCHDOG_LIMIT    = 4000;
  localparam int         DRAIN_CYCLES      = 12;
  localparam int         RANDOM_ITEMS      = 1150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t pending_words[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        sender_no_gaps = 1'b0;
  bit        hold_off_pending = 1'b0;

  rv32im_instruction_encoder_top dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_word(input logic [31:0] word, input logic err,
                                    input logic last_flag);
    out_item_t r;
    r.word  = word;
    r.error = err;
    r.last  = last_flag;
    pending_words.push_back(r);
  endfunction

  // Expected machine word(s) for one accepted instruction.
  function automatic void encode_expected(input in_item_t instr);
    logic [31:0]        u;
    logic signed [31:0] s;
    logic [4:0]         rd, rs1, rs2;
    logic [6:0]         opc, f7;
    logic [2:0]         f3;
    logic [19:0]        upper;
    kind_t              kind;
    logic               known, in_range;
    u = instr.imm_value;
    s = instr.imm_value;
    rd = instr.dest_reg;
    rs1 = instr.src1_reg;
    rs2 = instr.src2_reg;
    known = 1'b1;
    kind = KIND_R;
    opc = OPC_OP;
    f3 = 3'd0;
    f7 = F7_BASE;
    case (instr.action)
      ACT_JAL:   begin kind = KIND_J;  opc = OPC_JAL; end
      ACT_J:     begin kind = KIND_JZ; opc = OPC_JAL; end
      ACT_ADD:   f3 = 3'd0;
      ACT_MUL:   begin f3 = 3'd0; f7 = F7_MULDIV; end
      ACT_SUB:   begin f3 = 3'd0; f7 = F7_ALT; end
      ACT_SLL:   f3 = 3'd1;
      ACT_MULH:  begin f3 = 3'd1; f7 = F7_MULDIV; end
      ACT_SLT:   f3 = 3'd2;
      ACT_SLTU:  f3 = 3'd3;
      ACT_XOR:   f3 = 3'd4;
      ACT_DIV:   begin f3 = 3'd4; f7 = F7_MULDIV; end
      ACT_SRL:   f3 = 3'd5;
      ACT_SRA:   begin f3 = 3'd5; f7 = F7_ALT; end
      ACT_OR:    f3 = 3'd6;
      ACT_REM:   begin f3 = 3'd6; f7 = F7_MULDIV; end
      ACT_AND:   f3 = 3'd7;
      ACT_LB:    begin kind = KIND_I;  opc = OPC_LOAD;   f3 = 3'd0; end
      ACT_LH:    begin kind = KIND_I;  opc = OPC_LOAD;   f3 = 3'd1; end
      ACT_LW:    begin kind = KIND_I;  opc = OPC_LOAD;   f3 = 3'd2; end
      ACT_LBU:   begin kind = KIND_I;  opc = OPC_LOAD;   f3 = 3'd4; end
      ACT_LHU:   begin kind = KIND_I;  opc = OPC_LOAD;   f3 = 3'd5; end
      ACT_ADDI:  begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd0; end
      ACT_MV:    kind = KIND_MV;
      ACT_SLLI:  begin kind = KIND_SH; opc = OPC_OPIMM;  f3 = 3'd1; end
      ACT_SLTI:  begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd2; end
      ACT_SLTIU: begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd3; end
      ACT_XORI:  begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd4; end
      ACT_SRLI:  begin kind = KIND_SH; opc = OPC_OPIMM;  f3 = 3'd5; end
      ACT_SRAI:  begin kind = KIND_SH; opc = OPC_OPIMM;  f3 = 3'd5; f7 = F7_ALT; end
      ACT_ORI:   begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd6; end
      ACT_ANDI:  begin kind = KIND_I;  opc = OPC_OPIMM;  f3 = 3'd7; end
      ACT_JALR:  begin kind = KIND_I;  opc = OPC_JALR;   f3 = 3'd0; end
      ACT_JR:    kind = KIND_JR;
      ACT_ECALL: kind = KIND_EC;
      ACT_SB:    begin kind = KIND_S;  opc = OPC_STORE;  f3 = 3'd0; end
      ACT_SH:    begin kind = KIND_S;  opc = OPC_STORE;  f3 = 3'd1; end
      ACT_SW:    begin kind = KIND_S;  opc = OPC_STORE;  f3 = 3'd2; end
      ACT_BEQ:   begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd0; end
      ACT_BEQZ:  begin kind = KIND_BZ; opc = OPC_BRANCH; f3 = 3'd0; end
      ACT_BNE:   begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd1; end
      ACT_BNEZ:  begin kind = KIND_BZ; opc = OPC_BRANCH; f3 = 3'd1; end
      ACT_BLT:   begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd4; end
      ACT_BGE:   begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd5; end
      ACT_BLTU:  begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd6; end
      ACT_BGEU:  begin kind = KIND_B;  opc = OPC_BRANCH; f3 = 3'd7; end
      ACT_AUIPC: begin kind = KIND_U;  opc = OPC_AUIPC; end
      ACT_LUI:   begin kind = KIND_U;  opc = OPC_LUI; end
      ACT_LI:    kind = KIND_LI;
      default:   known = 1'b0;
    endcase

    in_range = 1'b1;
    case (kind)
      KIND_I, KIND_S:  in_range = (s >= -2048) && (s <= 2047);
      KIND_SH:         in_range = (s >= 0) && (s <= 31);
      KIND_B, KIND_BZ: in_range = (s >= -4096) && (s <= 4094);
      KIND_U:          in_range = (s >= 0) && (s <= 1048575);
      KIND_J, KIND_JZ: in_range = (s >= -1048576) && (s <= 1048575);
      KIND_LI:         in_range = (u != 32'h8000_0000);
      default:         in_range = 1'b1;
    endcase

    if (!known || !in_range) begin
      push_word('0, 1'b1, 1'b1);
    end else begin
      case (kind)
        KIND_R:  push_word({f7, rs2, rs1, f3, rd, opc}, 1'b0, 1'b1);
        KIND_I:  push_word({u[11:0], rs1, f3, rd, opc}, 1'b0, 1'b1);
        KIND_SH: push_word({f7, u[4:0], rs1, f3, rd, opc}, 1'b0, 1'b1);
        KIND_MV: push_word({12'd0, rs1, 3'd0, rd, OPC_OPIMM}, 1'b0, 1'b1);
        KIND_JR: push_word({12'd0, rs1, 3'd0, 5'd0, OPC_JALR}, 1'b0, 1'b1);
        KIND_EC: push_word({25'd0, OPC_SYSTEM}, 1'b0, 1'b1);
        KIND_S:  push_word({u[11:5], rs2, rs1, f3, u[4:0], opc}, 1'b0, 1'b1);
        KIND_B:  push_word({u[12], u[10:5], rs2, rs1, f3, u[4:1], u[11], opc},
                           1'b0, 1'b1);
        KIND_BZ: push_word({u[12], u[10:5], 5'd0, rs1, f3, u[4:1], u[11], opc},
                           1'b0, 1'b1);
        KIND_U:  push_word({u[19:0], rd, opc}, 1'b0, 1'b1);
        KIND_J:  push_word({u[20], u[10:1], u[11], u[19:12], rd, opc}, 1'b0, 1'b1);
        KIND_JZ: push_word({u[20], u[10:1], u[11], u[19:12], 5'd0, opc}, 1'b0, 1'b1);
        default: begin
          if (s >= -2048 && s <= 2047) begin
            push_word({u[11:0], 5'd0, 3'd0, rd, OPC_OPIMM}, 1'b0, 1'b1);
          end else begin
            // addi sign-extends the low part, so the upper part rounds up
            upper = u[31:12] + {19'd0, u[11]};
            push_word({upper, rd, OPC_LUI}, 1'b0, 1'b0);
            push_word({u[11:0], rd, 3'd0, rd, OPC_OPIMM}, 1'b0, 1'b1);
          end
        end
      endcase
    end
  endfunction

  // Random instruction; the immediate mostly lands inside the mnemonic's range,
  // with its edges, one step past them and full 32-bit noise mixed in.
  function automatic in_item_t random_instr();
    in_item_t    it;
    int unsigned sel;
    longint      lo, hi, v;
    sel = $urandom_range(0, 99);
    if (sel < 8)
      it.action = 6'($urandom_range(FIRST_UNKNOWN_ACT, LAST_ACT_CODE));
    else if (sel < 22)
      it.action = ACT_LI;
    else
      it.action = 6'($urandom_range(ACT_JAL, ACT_LI));
    it.dest_reg = 5'($urandom_range(0, 31));
    it.src1_reg = 5'($urandom_range(0, 31));
    it.src2_reg = 5'($urandom_range(0, 31));

    case (it.action)
      ACT_LB, ACT_LH, ACT_LW, ACT_LBU, ACT_LHU, ACT_ADDI, ACT_SLTI, ACT_SLTIU,
      ACT_XORI, ACT_ORI, ACT_ANDI, ACT_JALR, ACT_SB, ACT_SH, ACT_SW: begin
        lo = -2048; hi = 2047;
      end
      ACT_SLLI, ACT_SRLI, ACT_SRAI: begin
        lo = 0; hi = 31;
      end
      ACT_BEQ, ACT_BEQZ, ACT_BNE, ACT_BNEZ, ACT_BLT, ACT_BGE, ACT_BLTU, ACT_BGEU: begin
        lo = -4096; hi = 4094;
      end
      ACT_AUIPC, ACT_LUI: begin
        lo = 0; hi = 1048575;
      end
      ACT_JAL, ACT_J: begin
        lo = -1048576; hi = 1048575;
      end
      ACT_LI: begin
        lo = -2147483647; hi = 2147483647;
      end
      default: begin
        lo = -2147483648; hi = 2147483647;
      end
    endcase

    sel = $urandom_range(0, 99);
    if (sel < 6)
      v = lo - 1;
    else if (sel < 10)
      v = hi + 1;
    else if (sel < 16)
      v = ($urandom_range(0, 1) != 0) ? lo : hi;
    else if (sel < 24)
      v = longint'($urandom);
    else if (it.action == ACT_LI && sel < 50)
      v = longint'($urandom_range(0, 4095)) - 2048;   // single addi form
    else
      v = lo + longint'($urandom) % (hi - lo + 1);
    it.imm_value = v[31:0];
    return it;
  endfunction

  // Offer one instruction; bursts of random length with random gaps between, none while sender_no_gaps is set.
  task automatic send_item(input in_item_t instr);
    int gap;
    if (burst_left == 0) begin
      gap = sender_no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= instr;
    do @(posedge clk); while (in_stall);
    encode_expected(instr);
  endtask

  task automatic issue(input logic [5:0] act, input logic [4:0] rd, input logic [4:0] rs1,
                       input logic [4:0] rs2, input logic [31:0] imm);
    in_item_t it;
    it.action    = act;
    it.dest_reg  = rd;
    it.src1_reg  = rs1;
    it.src2_reg  = rs2;
    it.imm_value = imm;
    send_item(it);
  endtask

  task automatic test_field_extremes();
    issue(ACT_ADD, 31, 31, 31, 32'h7fff_ffff);
    issue(ACT_SUB, 0, 0, 0, 32'h8000_0000);
    issue(ACT_ADDI, 31, 31, 0, 2047);
    issue(ACT_LW, 1, 2, 0, -2048);
    issue(ACT_ANDI, 3, 4, 0, 2048);
    issue(ACT_SW, 0, 31, 31, -2048);
    issue(ACT_SB, 0, 1, 2, -2049);
    issue(ACT_BGEU, 0, 31, 31, 4094);
    issue(ACT_BLT, 0, 5, 6, -4096);
    issue(ACT_BEQ, 0, 5, 6, 4095);
    issue(ACT_LUI, 31, 0, 0, 1048575);
    issue(ACT_AUIPC, 7, 0, 0, -1);
    issue(ACT_JAL, 31, 0, 0, 1048575);
    issue(ACT_JAL, 1, 0, 0, -1048577);
  endtask

  task automatic test_special_cases();
    issue(ACT_MV, 5, 9, 0, 32'hdead_beef);
    issue(ACT_JR, 7, 3, 11, 100);
    issue(ACT_ECALL, 31, 31, 31, -1);
    issue(ACT_BEQZ, 0, 8, 31, -2);
    issue(ACT_BNEZ, 0, 9, 17, 4094);
    issue(ACT_J, 31, 0, 0, -1048576);
    issue(ACT_SRAI, 2, 3, 0, 31);
    issue(ACT_SLLI, 2, 3, 0, 32);
    issue(ACT_LI, 10, 0, 0, 2047);
    issue(ACT_LI, 11, 0, 0, 2048);
    issue(ACT_LI, 12, 0, 0, 32'h1234_5800);   // low part negative: lui rounds up
    issue(ACT_LI, 13, 0, 0, -2147483647);
    issue(ACT_LI, 14, 0, 0, 32'h8000_0000);
    issue(LAST_ACT_CODE, 1, 2, 3, 0);
  endtask

  // Output held off while input keeps coming: the pipe fills and in_stall rises.
  task automatic test_output_hold_off();
    in_item_t it;
    int       k;
    hold_off_pending = 1'b1;
    sender_no_gaps = 1'b1;
    for (k = 0; k < 24; k++) begin
      it = random_instr();
      if (k % 2 == 0) begin
        it.action = ACT_LI;
        it.imm_value = $urandom | 32'h0010_0800;
      end
      send_item(it);
    end
    sender_no_gaps = 1'b0;
  endtask

  task automatic test_random_stream();
    repeat (RANDOM_ITEMS) send_item(random_instr());
  endtask

  // Receiver stall: segments of none / light / fixed pattern / heavy stalling,
  // plus one long hold-off on request.
  initial begin
    int         stall_mode;
    int         stall_seg;
    logic [7:0] stall_pattern;
    logic       stall_now;
    stall_mode = 0;
    stall_seg = 0;
    stall_pattern = '0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_pending = 1'b0;
      end else begin
        if (stall_seg == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_seg = $urandom_range(10, 80);
          stall_pattern = 8'($urandom);
        end
        stall_seg--;
        case (stall_mode)
          0:       stall_now = 1'b0;
          1:       stall_now = ($urandom_range(0, 3) == 0);
          2:       stall_now = stall_pattern[stall_seg % 8];
          default: stall_now = ($urandom_range(0, 3) != 0);
        endcase
        out_stall <= stall_now;
        @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result word %h error %b last %b", $realtime,
                   out_data.word, out_data.error, out_data.last);
      end else begin
        want = pending_words.pop_front();
        if (out_data.word !== want.word || out_data.error !== want.error ||
            out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch word %h/%h error %b/%b last %b/%b (exp/act)",
                     $realtime, want.word, out_data.word, want.error, out_data.error,
                     want.last, out_data.last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_special_cases();
    test_output_hold_off();
    test_random_stream();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/rvenc_pkg.sv
sv/rvenc_front.sv
sv/rvenc_queue.sv
sv/rvenc_back.sv
sv/rv32im_instruction_encoder_top.sv
verif/rv32im_instruction_encoder_top_test.sv
